// ===== hdl/md5_message_digest_assert.svh =====
// Assertion macros for the MD5 digest block.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MD5_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A property that must hold at every clock edge, reset included.
`define MD5_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/md5_pkg.sv =====
`default_nettype none

package md5_pkg;

   // One request: a message byte and its markers.
   typedef struct packed {
      logic       end_of_message;
      logic       byte_present;
      logic [7:0] data_byte;
   } req_type;

   // One response: the 128-bit digest.
   typedef struct packed {
      logic [63:0] digest_high;
      logic [63:0] digest_low;
   } rsp_type;

   // One queue entry from the front part to the back part.
   typedef struct packed {
      logic       end_of_message;
      logic       byte_present;
      logic [7:0] data_byte;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_PAD,
      ST_FINISH,
      ST_EMIT
   } eng_state_type;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [7:0]  PAD_FIRST = 8'h80;
   localparam logic [5:0]  LEN_POSITION = 6'd56;

   localparam logic [31:0] STEP_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word index used by a given step.
   function automatic logic [3:0] word_index(input logic [5:0] step);
      logic [3:0] i;
      begin
         i = step[3:0];
         unique case (step[5:4])
            2'd0: word_index = i;
            2'd1: word_index = 4'((i << 2) + i + 4'd1);
            2'd2: word_index = 4'((i << 1) + i + 4'd5);
            default: word_index = 4'((i << 3) - i);
         endcase
      end
   endfunction

   // Round function of a given step.
   function automatic logic [31:0] round_fn(input logic [1:0] round,
         input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
      begin
         unique case (round)
            2'd0: round_fn = (b & c) | (~b & d);
            2'd1: round_fn = (b & d) | (c & ~d);
            2'd2: round_fn = b ^ c ^ d;
            default: round_fn = c ^ (b | ~d);
         endcase
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/md5_front.sv =====
`default_nettype none

// Front part: accepts requests, drops idle items and queues the rest.
module md5_front #(
   parameter int QueueDepth = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire md5_pkg::req_type req_payload,
   output logic                  job_valid,
   input  wire logic             job_take,
   output md5_pkg::job_type      job_data
);

   localparam int PtrWidth = $clog2(QueueDepth);

   md5_pkg::job_type      queue_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;
   logic                  accept;
   logic                  push;
   logic                  pop;

   // Items that carry no byte and no end marker are consumed without effect.
   assign req_stall = (count_ff == (PtrWidth+1)'(QueueDepth));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_payload.byte_present || req_payload.end_of_message);
   assign job_valid = (count_ff != '0);
   assign pop       = job_valid && job_take;
   assign job_data  = queue_ff[rd_ptr_ff];

   // Pointer and occupancy updates; pointers wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in  = count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= md5_pkg::job_type'(req_payload);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/md5_engine.sv =====
`default_nettype none

// Back part: fills the block, pads, runs one MD5 step per cycle.
module md5_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_take,
   input  wire md5_pkg::job_type job_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output md5_pkg::rsp_type      rsp_payload
);

   md5_pkg::eng_state_type state_ff, state_in;
   logic [31:0] chain_ff [4];
   logic [31:0] block_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [63:0] bit_total_ff, len_ff;
   logic [5:0]  pos_ff, step_ff;
   logic        finish_ff;
   logic        end_ff;
   logic        len_zone_ff;
   logic        len_done_ff;
   logic        rsp_valid_ff;
   md5_pkg::rsp_type rsp_ff;

   logic        put_en;
   logic [7:0]  put_byte;
   logic        start_compress;
   logic [31:0] f_val, t_val, rot_val, new_b;
   logic [4:0]  rot_amt;
   logic [1:0]  round;
   logic        done_step;

   assign round   = step_ff[5:4];
   assign rot_amt = md5_pkg::ROT_AMOUNT[{round, step_ff[1:0]}];
   assign f_val   = md5_pkg::round_fn(round, b_ff, c_ff, d_ff);
   assign t_val   = a_ff + f_val + block_ff[md5_pkg::word_index(step_ff)]
                    + md5_pkg::STEP_CONST[step_ff];
   assign rot_val = (t_val << rot_amt) | (t_val >> (6'd32 - {1'b0, rot_amt}));
   assign new_b   = b_ff + rot_val;
   assign done_step = (step_ff == 6'd63);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            if (job_valid) begin
               if (job_data.byte_present && pos_ff == 6'd63) begin
                  state_in = md5_pkg::ST_COMPRESS;
               end else if (job_data.end_of_message) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_COMPRESS: begin
            if (done_step) begin
               state_in = end_ff ? md5_pkg::ST_FINISH : md5_pkg::ST_IDLE;
            end
         end
         md5_pkg::ST_PAD: begin
            if (pos_ff == 6'd63) begin
               state_in = md5_pkg::ST_COMPRESS;
            end
         end
         md5_pkg::ST_FINISH: begin
            if (len_done_ff) begin
               state_in = md5_pkg::ST_EMIT;
            end else begin
               state_in = md5_pkg::ST_PAD;
            end
         end
         md5_pkg::ST_EMIT: begin
            if (!rsp_valid_ff) begin
               state_in = md5_pkg::ST_IDLE;
            end
         end
         default: state_in = md5_pkg::ST_IDLE;
      endcase
   end

   // Output and datapath controls.
   always_comb begin
      job_take       = 1'b0;
      put_en         = 1'b0;
      put_byte       = job_data.data_byte;
      start_compress = 1'b0;
      unique case (state_ff)
         md5_pkg::ST_IDLE: begin
            job_take = job_valid;
            put_en   = job_valid && job_data.byte_present;
            start_compress = put_en && (pos_ff == 6'd63);
         end
         md5_pkg::ST_PAD: begin
            put_en = 1'b1;
            start_compress = (pos_ff == 6'd63);
            if (finish_ff) begin
               put_byte = md5_pkg::PAD_FIRST;
            end else if (len_zone_ff && pos_ff >= md5_pkg::LEN_POSITION) begin
               put_byte = len_ff[8*pos_ff[2:0] +: 8];
            end else begin
               put_byte = 8'h00;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= md5_pkg::ST_IDLE;
         pos_ff       <= '0;
         bit_total_ff <= '0;
         step_ff      <= '0;
         finish_ff    <= 1'b0;
         end_ff       <= 1'b0;
         len_zone_ff  <= 1'b0;
         len_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (put_en) begin
            pos_ff <= pos_ff + 6'd1;
         end
         unique case (state_ff)
            md5_pkg::ST_IDLE: begin
               if (job_valid) begin
                  if (job_data.byte_present) begin
                     bit_total_ff <= bit_total_ff + 64'd8;
                  end
                  if (job_data.end_of_message) begin
                     // The first pad byte is placed on entry to padding.
                     finish_ff <= 1'b1;
                     end_ff    <= 1'b1;
                  end
               end
            end
            md5_pkg::ST_COMPRESS: begin
               step_ff <= step_ff + 6'd1;
               if (done_step) begin
                  chain_ff[0] <= chain_ff[0] + d_ff;
                  chain_ff[1] <= chain_ff[1] + new_b;
                  chain_ff[2] <= chain_ff[2] + b_ff;
                  chain_ff[3] <= chain_ff[3] + c_ff;
                  // The pad byte went into the previous block, so the length
                  // belongs at the end of the next one.
                  if (end_ff && !finish_ff) begin
                     len_zone_ff <= 1'b1;
                  end
               end
            end
            md5_pkg::ST_PAD: begin
               finish_ff <= 1'b0;
               // A pad byte ahead of the length field leaves room for it.
               if (finish_ff && pos_ff < md5_pkg::LEN_POSITION) begin
                  len_zone_ff <= 1'b1;
               end
               if (pos_ff == 6'd63) begin
                  len_done_ff <= len_zone_ff;
               end
            end
            md5_pkg::ST_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  bit_total_ff <= '0;
                  pos_ff       <= '0;
                  end_ff       <= 1'b0;
                  len_zone_ff  <= 1'b0;
                  len_done_ff  <= 1'b0;
                  chain_ff     <= '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C,
                                    md5_pkg::IV_D};
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers: block, working words, length and result.
   always_ff @(posedge clock) begin
      if (put_en) begin
         block_ff[pos_ff[5:2]][8*pos_ff[1:0] +: 8] <= put_byte;
      end
      if (state_ff == md5_pkg::ST_IDLE && job_valid && job_data.end_of_message) begin
         len_ff <= bit_total_ff + (job_data.byte_present ? 64'd8 : 64'd0);
      end
      if (start_compress) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (state_ff == md5_pkg::ST_COMPRESS) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= new_b;
      end
      if (state_ff == md5_pkg::ST_EMIT && !rsp_valid_ff) begin
         rsp_ff.digest_low  <= {chain_ff[1], chain_ff[0]};
         rsp_ff.digest_high <= {chain_ff[3], chain_ff[2]};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/md5_message_digest.sv =====
// MD5 message digest, one message byte per request.
// Request channel: req_valid / req_stall with req_payload holding data_byte,
// byte_present and end_of_message. A request with neither byte nor end marker
// is taken and has no effect; an end marker alone finishes an empty tail.
// Response channel: rsp_valid / rsp_stall with rsp_payload holding the
// 128-bit digest, byte 0 of the digest in digest_low bits 7:0.
// A small request queue separates intake from the hashing engine, so new
// requests are taken while the engine compresses or a digest waits.
// The engine stores one queued byte per cycle while idle and runs one MD5
// step per cycle; it takes no bytes while it pads, compresses or waits.
// At end of message, padding writes one byte per cycle up to the block end,
// each padded block is compressed, then the engine registers the digest.
// One engine limits the block to one message at a time.
// Reset is synchronous and active high: the queue empties, the chaining
// words return to the standard initial values and any pending digest drops.
// While rsp_stall is high the digest holds and the engine waits at the next
// digest; requests are taken until the queue is full, then req_stall rises.
`default_nettype none

module md5_message_digest #(
   parameter int QueueDepth = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire md5_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output md5_pkg::rsp_type      rsp_payload
);

   logic             job_valid;
   logic             job_take;
   md5_pkg::job_type job_data;

   md5_front #(.QueueDepth(QueueDepth)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .job_valid   (job_valid),
      .job_take    (job_take),
      .job_data    (job_data)
   );

   md5_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_take    (job_take),
      .job_data    (job_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`include "md5_message_digest_assert.svh"

   // The engine only takes queued work when the queue holds some.
   `MD5_ASSERT(a_take_needs_job, clock, reset, !job_take || job_valid, "take from empty queue")
   // A pending response is never dropped while stalled.
   `MD5_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "response dropped")
   // After reset no response is pending.
   `MD5_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "response after reset")

endmodule

`default_nettype wire

// ===== tb/sv/md5_message_digest_test.sv =====
`timescale 1ns / 100ps

module md5_message_digest_test;

   localparam int CycleLimit = 1000000;
   localparam int DrainCycles = 250;
   localparam int LongHoldCycles = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   md5_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   md5_pkg::rsp_type rsp_payload;

   md5_message_digest u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // Predicted hashing state.
   logic [31:0] chain_state [4];
   logic [31:0] block_buffer [16];
   logic [63:0] message_bits;
   logic [5:0]  fill_position;
   md5_pkg::rsp_type digest_queue [$];

   int idle_percent = 0;
   int stall_percent = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_count = 0;
   int request_count = 0;
   int message_count = 0;
   int byte_count = 0;
   int digest_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] rot_left32(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   // One MD5 compression of the buffered block into the chaining words.
   function automatic void compress_block();
      logic [31:0] a, b, c, d, f, t, nb;
      int g;
      a = chain_state[0];
      b = chain_state[1];
      c = chain_state[2];
      d = chain_state[3];
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = a + f + block_buffer[g] + md5_pkg::STEP_CONST[i];
         nb = b + rot_left32(t, md5_pkg::ROT_AMOUNT[(i / 16) * 4 + i % 4]);
         a = d;
         d = c;
         c = b;
         b = nb;
      end
      chain_state[0] += a;
      chain_state[1] += b;
      chain_state[2] += c;
      chain_state[3] += d;
   endfunction

   function automatic void absorb_byte(input logic [7:0] value);
      block_buffer[fill_position[5:2]][fill_position[1:0] * 8 +: 8] = value;
      fill_position++;
      if (fill_position == 6'd0) begin
         compress_block();
      end
   endfunction

   function automatic void start_message();
      chain_state[0] = md5_pkg::IV_A;
      chain_state[1] = md5_pkg::IV_B;
      chain_state[2] = md5_pkg::IV_C;
      chain_state[3] = md5_pkg::IV_D;
      message_bits = '0;
      fill_position = '0;
   endfunction

   // Update the prediction for one accepted request.
   function automatic void predict_digest(input md5_pkg::req_type req);
      logic [63:0] length_bits;
      if (req.byte_present) begin
         absorb_byte(req.data_byte);
         message_bits += 64'd8;
      end
      if (req.end_of_message) begin
         length_bits = message_bits;
         absorb_byte(md5_pkg::PAD_FIRST);
         while (fill_position != md5_pkg::LEN_POSITION) begin
            absorb_byte(8'h00);
         end
         for (int k = 0; k < 8; k++) begin
            absorb_byte(length_bits[8 * k +: 8]);
         end
         digest_queue.push_back({chain_state[3], chain_state[2],
                                 chain_state[1], chain_state[0]});
         start_message();
      end
   endfunction

   // Response stall: random, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count--;
      end else if (holds_done < holds_asked) begin
         holds_done++;
         hold_count = LongHoldCycles;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_percent;
      end
   end

   // Compare each accepted digest with the oldest prediction.
   always @(negedge clock) begin
      md5_pkg::rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: digest with none expected: %h", $time, rsp_payload);
            error_count++;
         end else begin
            expected = digest_queue.pop_front();
            digest_count++;
            if (rsp_payload.digest_low !== expected.digest_low) begin
               $display("%0t: digest_low expected %h actual %h", $time,
                        expected.digest_low, rsp_payload.digest_low);
               error_count++;
            end
            if (rsp_payload.digest_high !== expected.digest_high) begin
               $display("%0t: digest_high expected %h actual %h", $time,
                        expected.digest_high, rsp_payload.digest_high);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d digests outstanding", $time,
                  digest_queue.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offer one request, with a random idle gap first, until it is taken.
   task automatic send_request(input logic [7:0] value, input logic present,
                               input logic last);
      md5_pkg::req_type req;
      logic taken;
      req.data_byte = value;
      req.byte_present = present;
      req.end_of_message = last;
      if ($urandom_range(99) < idle_percent) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < idle_percent);
      end
      req_valid <= 1'b1;
      req_payload <= req;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_digest(req);
      if (present || last) begin
         request_count++;
      end
      if (present) begin
         byte_count++;
      end
      if (last) begin
         message_count++;
      end
   endtask

   // A message of random bytes, closed on its last byte or by an empty marker.
   task automatic send_message(input int length, input bit marker_end);
      for (int i = 0; i < length; i++) begin
         send_request(8'($urandom_range(255)), 1'b1, (i == length - 1) && !marker_end);
      end
      if (marker_end || length == 0) begin
         send_request(8'($urandom_range(255)), 1'b0, 1'b1);
      end
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_request(text[i], 1'b1, i == text.len() - 1);
      end
   endtask

   task automatic test_directed();
      idle_percent = 0;
      stall_percent = 0;
      // Empty message by an end marker alone.
      send_request(8'h00, 1'b0, 1'b1);
      send_text("abc");
      // Byte extremes, with an idle request in the middle of a message.
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'ha5, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hff, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_text("message digest");
   endtask

   task automatic test_random(input int idle_pct, input int stall_pct,
                              input int count);
      int goal;
      int pick;
      int length;
      idle_percent = idle_pct;
      stall_percent = stall_pct;
      goal = request_count + count;
      while (request_count < goal) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            length = $urandom_range(12);
         end else if (pick < 90) begin
            length = $urandom_range(70, 50);
         end else begin
            length = $urandom_range(140, 100);
         end
         if ($urandom_range(9) == 0) begin
            send_request(8'($urandom_range(255)), 1'b0, 1'b0);
         end
         send_message(length, $urandom_range(3) == 0);
      end
   endtask

   // Long response hold-off while requests keep coming, to fill the request queue.
   task automatic test_backpressure();
      idle_percent = 0;
      stall_percent = 0;
      holds_asked++;
      for (int m = 0; m < 4; m++) begin
         send_message(15, 1'b0);
      end
   endtask

   initial begin
      start_message();
      for (int i = 0; i < 16; i++) begin
         block_buffer[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(0, 0, 100);
      test_random(74, 0, 100);
      test_backpressure();
      test_random(0, 74, 100);
      test_random(36, 36, 100);

      req_valid <= 1'b0;
      while (digest_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      $display("Hashed %0d messages from %0d bytes, %0d requests, %0d digests checked.",
               message_count, byte_count, request_count, digest_count);
      $display("Covered empty messages, block boundaries, idle requests and stalls.");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
